// ===== src/rsc_pkg.sv =====
package rsc_pkg;

  typedef enum logic [1:0] {
    MODE_RUN  = 2'd0,
    MODE_STOP = 2'd1,
    MODE_MENU = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    KIND_CMD   = 2'd0,
    KIND_TICK  = 2'd1,
    KIND_RESET = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    REG_ALARM_NEAR = 2'd0,
    REG_ALARM_FAR  = 2'd1,
    REG_SWEEP_STEP = 2'd2,
    REG_SWEEP_MAX  = 2'd3
  } reg_idx_e;

  localparam logic [7:0] CMD_START_STOP = 8'h73; // 's'
  localparam logic [7:0] CMD_MENU       = 8'h6d; // 'm'
  localparam logic [7:0] CMD_FLIP       = 8'h65; // 'e'

  localparam int unsigned RangeW = 10;
  localparam int unsigned AngleW = 8;
  localparam int unsigned StepW  = 7;
  localparam int unsigned CfgW   = 10;

  localparam logic [RangeW-1:0] NEAR_RST = 10'd2;
  localparam logic [RangeW-1:0] FAR_RST  = 10'd40;
  localparam logic [StepW-1:0]  STEP_RST = 7'd2;
  localparam logic [AngleW-1:0] MAX_RST  = 8'd180;

endpackage

// ===== src/radar_sweep_controller.sv =====
// Path: each item passes the input register, then the result register, before its result is
// offered on out_valid_o.
// Throughput: one item per cycle while results are taken; a stalled result holds the input
// register, and in_ready_o drops once that register is also full.
// State (mode, direction, angle, choice, buzzer) is updated as the item leaves the input register.
// Reset (rst_ni low, asynchronous) returns to running, rising, angle 0, buzzer off, and
// loads the default thresholds; no item is pending afterwards.
module radar_sweep_controller (
  input  logic                        clk_i,
  input  logic                        rst_ni,

  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [1:0]                  kind_i,
  input  logic [7:0]                  command_i,
  input  logic [rsc_pkg::RangeW-1:0]  range_cm_i,

  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [1:0]                  mode_o,
  output logic                        buzzer_on_o,
  output logic                        report_valid_o,
  output logic [rsc_pkg::AngleW-1:0]  report_angle_o,
  output logic [rsc_pkg::RangeW-1:0]  report_range_o,
  output logic [rsc_pkg::AngleW-1:0]  servo_angle_o,
  output logic                        end_pause_o,
  output logic                        sweep_down_o,
  output logic                        menu_choice_o,
  output logic                        saved_o,

  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_index_i,
  input  logic [rsc_pkg::CfgW-1:0]    cfg_data_i
);

  // configuration
  logic [rsc_pkg::RangeW-1:0] near_q, far_q;
  logic [rsc_pkg::StepW-1:0]  step_q;
  logic [rsc_pkg::AngleW-1:0] max_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      near_q <= rsc_pkg::NEAR_RST;
      far_q  <= rsc_pkg::FAR_RST;
      step_q <= rsc_pkg::STEP_RST;
      max_q  <= rsc_pkg::MAX_RST;
    end else if (cfg_we_i) begin
      unique case (rsc_pkg::reg_idx_e'(cfg_index_i))
        rsc_pkg::REG_ALARM_NEAR: near_q <= cfg_data_i;
        rsc_pkg::REG_ALARM_FAR:  far_q  <= cfg_data_i;
        rsc_pkg::REG_SWEEP_STEP: step_q <= cfg_data_i[rsc_pkg::StepW-1:0];
        rsc_pkg::REG_SWEEP_MAX:  max_q  <= cfg_data_i[rsc_pkg::AngleW-1:0];
        default: ;
      endcase
    end
  end

  // input register
  logic                       in_vld_q;
  logic [1:0]                 kind_q;
  logic [7:0]                 cmd_q;
  logic [rsc_pkg::RangeW-1:0] dist_q;
  logic                       out_vld_q;
  logic                       advance;

  assign advance    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      kind_q <= kind_i;
      cmd_q  <= command_i;
      dist_q <= range_cm_i;
    end
  end

  // architectural state
  rsc_pkg::mode_e             mode_q, mode_d;
  logic                       dir_q, dir_d;
  logic [rsc_pkg::AngleW-1:0] angle_q, angle_d;
  logic                       choice_q, choice_d;
  logic                       buzz_q, buzz_d;
  logic                       rep_vld_d, pause_d, saved_d;
  logic [rsc_pkg::AngleW-1:0] rep_angle_d;
  logic [rsc_pkg::RangeW-1:0] rep_range_d;
  logic [rsc_pkg::AngleW:0]   angle_up;
  logic                       in_window;

  assign angle_up  = {1'b0, angle_q} + {{(rsc_pkg::AngleW + 1 - rsc_pkg::StepW){1'b0}}, step_q};
  assign in_window = (dist_q >= near_q) && (dist_q < far_q);

  always_comb begin
    mode_d      = mode_q;
    dir_d       = dir_q;
    angle_d     = angle_q;
    choice_d    = choice_q;
    buzz_d      = buzz_q;
    rep_vld_d   = 1'b0;
    rep_angle_d = '0;
    rep_range_d = '0;
    pause_d     = 1'b0;
    saved_d     = 1'b0;

    case (kind_q)
      rsc_pkg::KIND_RESET: begin
        mode_d   = rsc_pkg::MODE_RUN;
        dir_d    = 1'b0;
        angle_d  = '0;
        choice_d = 1'b0;
        buzz_d   = 1'b0;
      end
      rsc_pkg::KIND_CMD: begin
        case (cmd_q)
          rsc_pkg::CMD_START_STOP: begin
            if (mode_q == rsc_pkg::MODE_RUN) mode_d = rsc_pkg::MODE_STOP;
            else if (mode_q == rsc_pkg::MODE_STOP) mode_d = rsc_pkg::MODE_RUN;
          end
          rsc_pkg::CMD_MENU: begin
            if (mode_q == rsc_pkg::MODE_STOP) begin
              mode_d   = rsc_pkg::MODE_MENU;
              choice_d = dir_q;
            end else if (mode_q == rsc_pkg::MODE_MENU) begin
              dir_d   = choice_q;
              mode_d  = rsc_pkg::MODE_STOP;
              saved_d = 1'b1;
            end
          end
          rsc_pkg::CMD_FLIP: begin
            if (mode_q == rsc_pkg::MODE_MENU) choice_d = !choice_q;
          end
          default: ;
        endcase
      end
      rsc_pkg::KIND_TICK: begin
        if (mode_q == rsc_pkg::MODE_RUN) begin
          buzz_d      = in_window ? !buzz_q : 1'b0;
          rep_vld_d   = 1'b1;
          rep_angle_d = angle_q;
          rep_range_d = dist_q;
          if (!dir_q) begin
            if (angle_up >= {1'b0, max_q}) begin
              angle_d = max_q;
              dir_d   = 1'b1;
              pause_d = 1'b1;
            end else begin
              angle_d = angle_up[rsc_pkg::AngleW-1:0];
            end
          end else begin
            if (angle_q <= {1'b0, step_q}) begin
              angle_d = '0;
              dir_d   = 1'b0;
              pause_d = 1'b1;
            end else begin
              angle_d = angle_q - {1'b0, step_q};
            end
          end
        end
      end
      default: ;
    endcase

    // buzzer is silent outside running
    if (mode_d != rsc_pkg::MODE_RUN) buzz_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= rsc_pkg::MODE_RUN;
      dir_q    <= 1'b0;
      angle_q  <= '0;
      choice_q <= 1'b0;
      buzz_q   <= 1'b0;
    end else if (advance) begin
      mode_q   <= mode_d;
      dir_q    <= dir_d;
      angle_q  <= angle_d;
      choice_q <= choice_d;
      buzz_q   <= buzz_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  logic [1:0]                 res_mode_q;
  logic                       res_buzz_q, res_rep_vld_q, res_pause_q, res_dir_q;
  logic                       res_choice_q, res_saved_q;
  logic [rsc_pkg::AngleW-1:0] res_rep_angle_q, res_angle_q;
  logic [rsc_pkg::RangeW-1:0] res_rep_range_q;

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_mode_q      <= mode_d;
      res_buzz_q      <= buzz_d;
      res_rep_vld_q   <= rep_vld_d;
      res_rep_angle_q <= rep_angle_d;
      res_rep_range_q <= rep_range_d;
      res_angle_q     <= angle_d;
      res_pause_q     <= pause_d;
      res_dir_q       <= dir_d;
      res_choice_q    <= choice_d;
      res_saved_q     <= saved_d;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign mode_o         = res_mode_q;
  assign buzzer_on_o    = res_buzz_q;
  assign report_valid_o = res_rep_vld_q;
  assign report_angle_o = res_rep_angle_q;
  assign report_range_o = res_rep_range_q;
  assign servo_angle_o  = res_angle_q;
  assign end_pause_o    = res_pause_q;
  assign sweep_down_o   = res_dir_q;
  assign menu_choice_o  = res_choice_q;
  assign saved_o        = res_saved_q;

endmodule
